// ----- rtl/core/assert_macros.svh -----
// ---------------------------------------------------------------------------
// Assertion macros shared by the RTL
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked check, switched off while reset is high
`define NPC_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// clocked check that also holds through reset
`define NPC_ASSERT_NR(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- rtl/core/npc_pkg.sv -----
// ---------------------------------------------------------------------------
// npc_pkg
// Types, palette tables and helpers for the nearest palette colour block.
// ---------------------------------------------------------------------------
`default_nettype none

package npc_pkg;

  typedef struct packed {
    logic [7:0] b;
    logic [7:0] g;
    logic [7:0] r;
  } bgr_t;

  // control that travels alongside an item
  typedef struct packed {
    logic valid;
    logic sel;
  } ctl_t;

  localparam int NUM_A     = 26;
  localparam int NUM_B     = 8;
  localparam int NUM_LANES = NUM_A;
  localparam int IDX_W     = 5;
  localparam int B_IDX_W   = 3;
  localparam int LEVELS    = 5;
  localparam int LEAVES    = 1 << LEVELS;
  localparam int DIST_W    = 18;
  localparam int SQ_W      = 16;
  localparam logic [DIST_W-1:0] DIST_MAX = '1;

  // lane stages + comparator tree + output register
  localparam int LANE_STAGES = 3;
  localparam int PIPE_LAT    = LANE_STAGES + LEVELS + 1;

  localparam bgr_t TBL_A [NUM_A] = '{
    '{8'd120, 8'd138, 8'd244}, '{8'd198, 8'd198, 8'd240},
    '{8'd230, 8'd189, 8'd245}, '{8'd246, 8'd160, 8'd198},
    '{8'd150, 8'd135, 8'd237}, '{8'd160, 8'd153, 8'd238},
    '{8'd127, 8'd169, 8'd245}, '{8'd159, 8'd212, 8'd238},
    '{8'd149, 8'd218, 8'd166}, '{8'd202, 8'd213, 8'd139},
    '{8'd227, 8'd215, 8'd145}, '{8'd228, 8'd196, 8'd125},
    '{8'd244, 8'd173, 8'd138}, '{8'd248, 8'd189, 8'd183},
    '{8'd245, 8'd211, 8'd202}, '{8'd224, 8'd192, 8'd184},
    '{8'd203, 8'd173, 8'd165}, '{8'd183, 8'd154, 8'd147},
    '{8'd162, 8'd135, 8'd128}, '{8'd141, 8'd115, 8'd110},
    '{8'd120, 8'd96,  8'd91},  '{8'd100, 8'd77,  8'd73},
    '{8'd79,  8'd58,  8'd54},  '{8'd58,  8'd39,  8'd36},
    '{8'd48,  8'd32,  8'd30},  '{8'd38,  8'd25,  8'd24}
  };

  localparam bgr_t TBL_B [NUM_B] = '{
    '{8'd54,  8'd43,  8'd0},   '{8'd66,  8'd54,  8'd7},
    '{8'd117, 8'd110, 8'd88},  '{8'd131, 8'd123, 8'd101},
    '{8'd150, 8'd148, 8'd131}, '{8'd161, 8'd161, 8'd147},
    '{8'd227, 8'd246, 8'd253}, '{8'd0,   8'd137, 8'd181}
  };

  function automatic logic [7:0] abs_diff(input logic [7:0] x, input logic [7:0] y);
    return (x >= y) ? (x - y) : (y - x);
  endfunction

  function automatic bgr_t palette_entry(input logic sel, input logic [IDX_W-1:0] idx);
    bgr_t e;
    e = '0;
    if (sel) begin
      if (idx < IDX_W'(NUM_B)) e = TBL_B[idx[B_IDX_W-1:0]];
    end else begin
      if (idx < IDX_W'(NUM_A)) e = TBL_A[idx];
    end
    return e;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/core/nearest_palette_color.sv -----
// Pipeline: the result strobe done follows an accepted item through the
// 3 lane stages, 5 tree levels and 1 output register.
// Throughput: one item per cycle, sustained; busy is low except around reset.
// The 26 distance lanes and the five-level registered minimum tree set the depth.
// Reset clears the valid pipeline and palette_select, and holds busy high until
// the cycle after rst falls, as busy is registered; the receiver cannot stall results.
// ---------------------------------------------------------------------------
// nearest_palette_color
// Nearest entry of a built-in BGR palette to one pixel, with its index.
// ---------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module nearest_palette_color (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  output logic                      busy,
  input  logic [7:0]                blue_in,
  input  logic [7:0]                green_in,
  input  logic [7:0]                red_in,
  output logic                      done,
  output logic [7:0]                blue_out,
  output logic [7:0]                green_out,
  output logic [7:0]                red_out,
  output logic [npc_pkg::IDX_W-1:0] palette_index,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic                      cfg_data
);
  import npc_pkg::*;

  logic              palette_select;
  logic              accept;
  ctl_t              ctl [PIPE_LAT-1];
  bgr_t              pix;
  bgr_t              ent [NUM_LANES];
  logic              active [NUM_LANES];
  logic [DIST_W-1:0] lane_dist [NUM_LANES];
  logic [IDX_W-1:0]  best_idx;
  bgr_t              best_col;
  logic              out_sel;

  assign cfg_ready = ~rst;
  assign accept    = start & ~busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b1;
    end else begin
      busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      palette_select <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      palette_select <= cfg_data;
    end
  end

  // item control runs beside the lanes and the tree
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < PIPE_LAT-1; i++) ctl[i] <= '0;
    end else begin
      ctl[0] <= '{valid: accept, sel: palette_select};
      for (int i = 1; i < PIPE_LAT-1; i++) ctl[i] <= ctl[i-1];
    end
  end

  assign pix = '{b: blue_in, g: green_in, r: red_in};

  for (genvar k = 0; k < NUM_LANES; k++) begin : g_lane
    if (k < NUM_B) begin : g_both
      assign ent[k]    = palette_select ? TBL_B[k] : TBL_A[k];
      assign active[k] = 1'b1;
    end else begin : g_a_only
      assign ent[k]    = TBL_A[k];
      assign active[k] = ~palette_select;
    end

    npc_lane u_lane (
      .clk      (clk),
      .pix      (pix),
      .ent      (ent[k]),
      .active   (active[k]),
      .dist_sum (lane_dist[k])
    );
  end

  npc_min_tree u_tree (
    .clk       (clk),
    .leaf_dist (lane_dist),
    .best_idx  (best_idx)
  );

  assign best_col = palette_entry(ctl[PIPE_LAT-2].sel, best_idx);

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= ctl[PIPE_LAT-2].valid;
    end
  end

  always_ff @(posedge clk) begin
    blue_out      <= best_col.b;
    green_out     <= best_col.g;
    red_out       <= best_col.r;
    palette_index <= best_idx;
    out_sel       <= ctl[PIPE_LAT-2].sel;
  end

  `NPC_ASSERT(a_lat_fwd, clk, rst, accept |-> ##PIPE_LAT done, "item lost in pipeline")
  `NPC_ASSERT(a_lat_back, clk, rst, done |-> $past(accept, PIPE_LAT), "result without item")
  `NPC_ASSERT(a_idx_a, clk, rst, (done && !out_sel) |-> (palette_index < IDX_W'(NUM_A)),
              "index beyond first palette")
  `NPC_ASSERT(a_idx_b, clk, rst, (done && out_sel) |-> (palette_index < IDX_W'(NUM_B)),
              "index beyond second palette")
  `NPC_ASSERT_NR(a_rst, clk, rst |=> (!done && busy), "strobe or ready after reset")

endmodule

`default_nettype wire

// ----- rtl/core/npc_lane.sv -----
// ---------------------------------------------------------------------------
// npc_lane
// Squared distance from the pixel to one palette entry, three stages:
// absolute difference, square, sum.
// ---------------------------------------------------------------------------
`default_nettype none

module npc_lane (
  input  logic                       clk,
  input  npc_pkg::bgr_t              pix,
  input  npc_pkg::bgr_t              ent,
  input  logic                       active,
  output logic [npc_pkg::DIST_W-1:0] dist_sum
);
  import npc_pkg::*;

  logic [7:0]      ad_b, ad_g, ad_r;
  logic            act1;
  logic [SQ_W-1:0] sq_b, sq_g, sq_r;
  logic            act2;

  always_ff @(posedge clk) begin
    ad_b <= abs_diff(pix.b, ent.b);
    ad_g <= abs_diff(pix.g, ent.g);
    ad_r <= abs_diff(pix.r, ent.r);
    act1 <= active;
  end

  always_ff @(posedge clk) begin
    sq_b <= ad_b * ad_b;
    sq_g <= ad_g * ad_g;
    sq_r <= ad_r * ad_r;
    act2 <= act1;
  end

  // unused lanes of the short palette never win
  always_ff @(posedge clk) begin
    if (act2) begin
      dist_sum <= DIST_W'(sq_b) + DIST_W'(sq_g) + DIST_W'(sq_r);
    end else begin
      dist_sum <= DIST_MAX;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/core/npc_min_tree.sv -----
// ---------------------------------------------------------------------------
// npc_min_tree
// Registered pairwise minimum tree over the lane distances, one level per
// stage; the left (lower index) node wins a tie.
// ---------------------------------------------------------------------------
`default_nettype none

module npc_min_tree (
  input  logic                       clk,
  input  logic [npc_pkg::DIST_W-1:0] leaf_dist [npc_pkg::NUM_LANES],
  output logic [npc_pkg::IDX_W-1:0]  best_idx
);
  import npc_pkg::*;

  logic [DIST_W-1:0] pad_dist [LEAVES];
  logic [IDX_W-1:0]  pad_idx  [LEAVES];
  logic [DIST_W-1:0] node_dist [LEVELS][LEAVES/2];
  logic [IDX_W-1:0]  node_idx  [LEVELS][LEAVES/2];

  // spare leaves beyond the lanes sit at the largest distance
  for (genvar i = 0; i < LEAVES; i++) begin : g_pad
    if (i < NUM_LANES) begin : g_used
      assign pad_dist[i] = leaf_dist[i];
    end else begin : g_spare
      assign pad_dist[i] = DIST_MAX;
    end
    assign pad_idx[i] = IDX_W'(i);
  end

  for (genvar lv = 0; lv < LEVELS; lv++) begin : g_lvl
    for (genvar n = 0; n < (LEAVES >> (lv + 1)); n++) begin : g_node
      if (lv == 0) begin : g_leaf
        always_ff @(posedge clk) begin
          if (pad_dist[2*n+1] < pad_dist[2*n]) begin
            node_dist[lv][n] <= pad_dist[2*n+1];
            node_idx[lv][n]  <= pad_idx[2*n+1];
          end else begin
            node_dist[lv][n] <= pad_dist[2*n];
            node_idx[lv][n]  <= pad_idx[2*n];
          end
        end
      end else begin : g_inner
        always_ff @(posedge clk) begin
          if (node_dist[lv-1][2*n+1] < node_dist[lv-1][2*n]) begin
            node_dist[lv][n] <= node_dist[lv-1][2*n+1];
            node_idx[lv][n]  <= node_idx[lv-1][2*n+1];
          end else begin
            node_dist[lv][n] <= node_dist[lv-1][2*n];
            node_idx[lv][n]  <= node_idx[lv-1][2*n];
          end
        end
      end
    end
  end

  assign best_idx = node_idx[LEVELS-1][0];

endmodule

`default_nettype wire

// ----- tb/tb.sv -----
// ---------------------------------------------------------------------------
// tb
// Self-checking bench for nearest_palette_color: each pixel handed to the
// block gets a typed-in expectation or a predicted palette colour and index
// from an in-bench nearest-entry search over the selected built-in table.
// Results are matched in order.
module tb;
  import npc_pkg::*;

  localparam int IDLE_LIMIT  = 1000;
  localparam int CHUNK_ITEMS = 67;

  typedef struct packed {
    bgr_t             col;
    logic [IDX_W-1:0] idx;
  } match_t;

  // sel, pixel, expected typed in?, expected colour and index
  typedef struct packed {
    logic   sel;
    bgr_t   px;
    logic   known;
    match_t want;
  } row_t;

  localparam row_t DIRECTED [23] = '{
    {1'b0, 8'd0,   8'd0,   8'd0,   1'b0, 24'd0,                   5'd0},
    {1'b0, 8'd255, 8'd255, 8'd255, 1'b0, 24'd0,                   5'd0},
    {1'b0, 8'd255, 8'd0,   8'd0,   1'b0, 24'd0,                   5'd0},
    {1'b0, 8'd0,   8'd255, 8'd0,   1'b0, 24'd0,                   5'd0},
    {1'b0, 8'd0,   8'd0,   8'd255, 1'b0, 24'd0,                   5'd0},
    {1'b0, 8'd120, 8'd138, 8'd244, 1'b1, 8'd120, 8'd138, 8'd244, 5'd0},
    {1'b0, 8'd38,  8'd25,  8'd24,  1'b1, 8'd38,  8'd25,  8'd24,  5'd25},
    {1'b0, 8'd248, 8'd189, 8'd183, 1'b1, 8'd248, 8'd189, 8'd183, 5'd13},
    {1'b0, 8'd120, 8'd139, 8'd244, 1'b0, 24'd0,                   5'd0},
    {1'b0, 8'd214, 8'd193, 8'd242, 1'b0, 24'd0,                   5'd0},
    {1'b0, 8'd170, 8'd170, 8'd170, 1'b0, 24'd0,                   5'd0},
    {1'b1, 8'd54,  8'd43,  8'd0,   1'b1, 8'd54,  8'd43,  8'd0,   5'd0},
    {1'b1, 8'd227, 8'd246, 8'd253, 1'b1, 8'd227, 8'd246, 8'd253, 5'd6},
    {1'b1, 8'd0,   8'd137, 8'd181, 1'b1, 8'd0,   8'd137, 8'd181, 5'd7},
    // equidistant from entries 0 and 1: lower index wins
    {1'b1, 8'd62,  8'd46,  8'd4,   1'b1, 8'd54,  8'd43,  8'd0,   5'd0},
    {1'b1, 8'd0,   8'd0,   8'd0,   1'b1, 8'd54,  8'd43,  8'd0,   5'd0},
    {1'b1, 8'd255, 8'd255, 8'd255, 1'b0, 24'd0,                   5'd0},
    {1'b1, 8'd0,   8'd255, 8'd255, 1'b0, 24'd0,                   5'd0},
    {1'b1, 8'd255, 8'd0,   8'd255, 1'b0, 24'd0,                   5'd0},
    {1'b1, 8'd128, 8'd128, 8'd128, 1'b0, 24'd0,                   5'd0},
    {1'b0, 8'd0,   8'd0,   8'd0,   1'b1, 8'd38,  8'd25,  8'd24,  5'd25},
    {1'b0, 8'd128, 8'd128, 8'd128, 1'b0, 24'd0,                   5'd0},
    {1'b0, 8'd255, 8'd255, 8'd0,   1'b0, 24'd0,                   5'd0}
  };

  logic             clk;
  logic             rst       = 1'b1;
  logic             start     = 1'b0;
  logic [7:0]       blue_in   = 8'd0;
  logic [7:0]       green_in  = 8'd0;
  logic [7:0]       red_in    = 8'd0;
  logic             cfg_valid = 1'b0;
  logic             cfg_data  = 1'b0;
  logic             busy;
  logic             done;
  logic [7:0]       blue_out;
  logic [7:0]       green_out;
  logic [7:0]       red_out;
  logic [IDX_W-1:0] palette_index;
  logic             cfg_ready;

  // travels with the item: typed-in expectation instead of the prediction
  logic   row_known = 1'b0;
  match_t row_want  = '0;

  logic   sel_model = 1'b0;
  logic   cur_sel   = 1'b0;
  match_t expected_q [$];
  int     errors      = 0;
  int     n_tbl_a     = 0;
  int     n_tbl_b     = 0;
  int     n_writes    = 0;
  int     idle_cycles = 0;

  nearest_palette_color dut (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .blue_in      (blue_in),
    .green_in     (green_in),
    .red_in       (red_in),
    .done         (done),
    .blue_out     (blue_out),
    .green_out    (green_out),
    .red_out      (red_out),
    .palette_index(palette_index),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_data     (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic bgr_t tbl_entry(input logic sel, input int k);
    if (sel) return TBL_B[k];
    return TBL_A[k];
  endfunction

  // exhaustive scan, strict less-than keeps the lowest index on a tie
  function automatic match_t nearest_entry(input logic sel, input bgr_t px);
    int     n;
    int     d;
    int     best_d;
    int     db;
    int     dg;
    int     dr;
    bgr_t   e;
    match_t m;
    n      = sel ? NUM_B : NUM_A;
    best_d = 0;
    m      = '0;
    for (int k = 0; k < n; k++) begin
      e  = tbl_entry(sel, k);
      db = int'(px.b) - int'(e.b);
      dg = int'(px.g) - int'(e.g);
      dr = int'(px.r) - int'(e.r);
      d  = db * db + dg * dg + dr * dr;
      if (k == 0 || d < best_d) begin
        best_d = d;
        m.col  = e;
        m.idx  = IDX_W'(k);
      end
    end
    return m;
  endfunction

  function automatic logic [7:0] nudge(input logic [7:0] v);
    int t;
    t = int'(v) + int'($urandom_range(0, 16)) - 8;
    if (t < 0) t = 0;
    if (t > 255) t = 255;
    return 8'(t);
  endfunction

  function automatic logic [7:0] edge_or_any();
    case ($urandom_range(0, 2))
      0:       return 8'd0;
      1:       return 8'd255;
      default: return 8'($urandom);
    endcase
  endfunction

  // mix of uniform pixels, near-entry pixels, midpoints and channel extremes
  function automatic bgr_t random_pixel(input logic sel);
    int   n;
    int   mode;
    bgr_t a;
    bgr_t c;
    bgr_t px;
    n    = sel ? NUM_B : NUM_A;
    a    = tbl_entry(sel, $urandom_range(0, n - 1));
    c    = tbl_entry(sel, $urandom_range(0, n - 1));
    mode = $urandom_range(0, 99);
    if (mode < 45) begin
      px = 24'($urandom);
    end else if (mode < 75) begin
      px.b = nudge(a.b);
      px.g = nudge(a.g);
      px.r = nudge(a.r);
    end else if (mode < 90) begin
      px.b = 8'((int'(a.b) + int'(c.b)) / 2);
      px.g = 8'((int'(a.g) + int'(c.g)) / 2);
      px.r = 8'((int'(a.r) + int'(c.r)) / 2);
    end else begin
      px.b = edge_or_any();
      px.g = edge_or_any();
      px.r = edge_or_any();
    end
    return px;
  endfunction

  task automatic send_pixel(input bgr_t px, input logic known, input match_t want,
                            input int idle_pct);
    if ($urandom_range(0, 99) < idle_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, ($urandom_range(0, 3) == 0) ? 12 : 3)) @(posedge clk);
    end
    start     <= 1'b1;
    blue_in   <= px.b;
    green_in  <= px.g;
    red_in    <= px.r;
    row_known <= known;
    row_want  <= want;
    do @(posedge clk); while (busy);
  endtask

  // only written once the pipeline has drained
  task automatic set_palette(input logic v);
    start <= 1'b0;
    @(posedge clk);
    while (expected_q.size() != 0) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    cur_sel = v;
  endtask

  always @(posedge clk) begin
    match_t got;
    match_t want;
    bit     progress;
    if (rst) begin
      sel_model   = 1'b0;
      idle_cycles = 0;
    end else begin
      progress = 1'b0;
      if (done) begin
        progress = 1'b1;
        got.col.b = blue_out;
        got.col.g = green_out;
        got.col.r = red_out;
        got.idx   = palette_index;
        if (expected_q.size() == 0) begin
          $error("result with no pixel outstanding");
          errors++;
        end else begin
          want = expected_q.pop_front();
          if (got.col.b !== want.col.b) begin
            $error("blue_out: expected %0d, got %0d", want.col.b, got.col.b);
            errors++;
          end
          if (got.col.g !== want.col.g) begin
            $error("green_out: expected %0d, got %0d", want.col.g, got.col.g);
            errors++;
          end
          if (got.col.r !== want.col.r) begin
            $error("red_out: expected %0d, got %0d", want.col.r, got.col.r);
            errors++;
          end
          if (got.idx !== want.idx) begin
            $error("palette_index: expected %0d, got %0d", want.idx, got.idx);
            errors++;
          end
        end
      end
      if (start && !busy) begin
        progress = 1'b1;
        if (row_known) expected_q.push_back(row_want);
        else expected_q.push_back(nearest_entry(sel_model, {blue_in, green_in, red_in}));
        if (sel_model) n_tbl_b++;
        else n_tbl_a++;
      end
      if (cfg_valid && cfg_ready) begin
        progress  = 1'b1;
        sel_model = cfg_data;
        n_writes++;
      end
      if (progress) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("TB_ERROR");
        $finish;
      end
    end
  end

  initial begin
    int pct;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // first rows run on the reset palette, no write beforehand
    foreach (DIRECTED[i]) begin
      if (DIRECTED[i].sel != cur_sel) set_palette(DIRECTED[i].sel);
      send_pixel(DIRECTED[i].px, DIRECTED[i].known, DIRECTED[i].want, 11);
    end

    for (int phase = 0; phase < 3; phase++) begin
      pct = (phase == 0) ? 11 : (phase == 1) ? 69 : 0;
      for (int chunk = 0; chunk < 4; chunk++) begin
        set_palette(1'((chunk + phase) % 2));
        repeat (CHUNK_ITEMS) send_pixel(random_pixel(cur_sel), 1'b0, '0, pct);
      end
    end

    start <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (PIPE_LAT + 4) @(posedge clk);

    $display("Checked %0d pixels on the 26-entry table and %0d on the 8-entry table,",
             n_tbl_a, n_tbl_b);
    $display("with %0d palette writes across three input gap profiles.", n_writes);
    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// ----- nearest_palette_color.f -----
+incdir+rtl/core
rtl/core/npc_pkg.sv
rtl/core/npc_lane.sv
rtl/core/npc_min_tree.sv
rtl/core/nearest_palette_color.sv
tb/tb.sv
